FILE: hw/rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int DEF_SCREEN_ROWS = 24;
  localparam int DEF_SCREEN_COLS = 80;
  localparam int CELL_W          = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;
  localparam logic [7:0]        NEWLINE_CODE = 8'd10;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/text_console_writer_core.sv
// Plain append, ignored char, unused mode, out-of-range read: result in the cycle after accept.
// In-range read: via S_RD_WAIT, S_RD_OUT. Clear: one blank cell written per cycle on the store's write port.
// Scroll (append past last row): rows copied up one cell per cycle, then S_DRAIN, then last row blanked.
// Throughput: one beat per cycle for plain appends; busy stays high during in-range read, clear, scroll.
// Reset: synchronous; a clearing pass over all ROWS*COLS cells (1920 by default) runs with busy high.
// The result beat is held for one cycle only; the receiver cannot stall it.
`default_nettype none
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = DEF_SCREEN_COLS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t cmd,
  output logic          done,
  output out_item_t     result
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tcw_ctrl #(
    .ROWS (SCREEN_ROWS),
    .COLS (SCREEN_COLS),
    .AW   (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_screen_mem.sv
`default_nettype none
module tcw_screen_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH = DEF_SCREEN_ROWS * DEF_SCREEN_COLS,
  parameter int AW    = $clog2(DEF_SCREEN_ROWS * DEF_SCREEN_COLS)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int ROWS = DEF_SCREEN_ROWS,
  parameter int COLS = DEF_SCREEN_COLS,
  parameter int AW   = $clog2(DEF_SCREEN_ROWS * DEF_SCREEN_COLS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          cmd,
  output logic                   done,
  output out_item_t              result,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [CELL_W-1:0] mem_wdata,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [CELL_W-1:0] mem_rdata
);

  localparam int CELLS     = ROWS * COLS;
  localparam int RW        = $clog2(ROWS);
  localparam int CW        = $clog2(COLS);
  localparam int COPY_LAST = (ROWS - 1) * COLS - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_RD_OUT,
    S_COPY,
    S_DRAIN,
    S_FILL
  } state_t;

  state_t          state;
  logic [RW-1:0]   cur_row;
  logic [CW-1:0]   cur_col;
  logic [AW-1:0]   sweep;
  logic            report;
  // copy pipeline: read issued (pv1), read data ready (pv2)
  logic            pv1, pv2;
  logic [AW-1:0]   pa1, pa2;

  logic [RW:0]     row_inc;
  logic [CW:0]     col_inc;
  logic            is_nl;
  logic            col_wrap;
  logic [RW:0]     row_tmp;
  logic            need_scroll;
  logic [RW-1:0]   app_row;
  logic [CW-1:0]   app_col;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic            rd_in_range;

  assign busy = (state != S_IDLE);

  always_comb begin
    row_inc     = {1'b0, cur_row} + (RW+1)'(1);
    col_inc     = {1'b0, cur_col} + (CW+1)'(1);
    is_nl       = (cmd.char_code == NEWLINE_CODE);
    col_wrap    = is_nl || (32'(col_inc) >= COLS);
    app_col     = col_wrap ? '0 : col_inc[CW-1:0];
    row_tmp     = col_wrap ? row_inc : {1'b0, cur_row};
    need_scroll = (32'(row_tmp) >= ROWS);
    app_row     = need_scroll ? RW'(ROWS - 1) : row_tmp[RW-1:0];
    wr_addr     = AW'(32'(cur_row) * COLS + 32'(cur_col));
    rd_in_range = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_col) < COLS);
    rd_addr     = AW'(32'(cmd.read_row) * COLS + 32'(cmd.read_col));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      sweep   <= '0;
      report  <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
      done    <= 1'b0;
      mem_we  <= 1'b0;
      pv1     <= 1'b0;
      pv2     <= 1'b0;
    end else begin
      done   <= 1'b0;
      mem_we <= 1'b0;
      pv1    <= 1'b0;
      pv2    <= pv1;
      pa2    <= pa1;
      if (pv2) begin
        mem_we    <= 1'b1;
        mem_waddr <= pa2;
        mem_wdata <= mem_rdata;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            result.cursor_row <= 5'(cur_row);
            result.cursor_col <= 7'(cur_col);
            result.cell_char  <= '0;
            result.cell_attr  <= '0;
            unique case (cmd.mode)
              MODE_APPEND: begin
                if (cmd.char_code != '0) begin
                  cur_row <= app_row;
                  cur_col <= app_col;
                  if (!is_nl) begin
                    mem_we    <= 1'b1;
                    mem_waddr <= wr_addr;
                    mem_wdata <= {cmd.color, cmd.char_code};
                  end
                  if (need_scroll) begin
                    state <= S_COPY;
                    sweep <= '0;
                  end else begin
                    done              <= 1'b1;
                    result.cursor_row <= 5'(app_row);
                    result.cursor_col <= 7'(app_col);
                  end
                end else begin
                  done <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                sweep   <= '0;
                report  <= 1'b1;
                state   <= S_FILL;
              end
              MODE_READ: begin
                if (rd_in_range) begin
                  mem_raddr <= rd_addr;
                  state     <= S_RD_WAIT;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_RD_WAIT: begin
          state <= S_RD_OUT;
        end

        S_RD_OUT: begin
          done              <= 1'b1;
          result.cursor_row <= 5'(cur_row);
          result.cursor_col <= 7'(cur_col);
          result.cell_char  <= mem_rdata[7:0];
          result.cell_attr  <= mem_rdata[15:8];
          state             <= S_IDLE;
        end

        // one row up: read cell one row below, write it back through the pv1/pv2 pipeline
        S_COPY: begin
          mem_raddr <= AW'(32'(sweep) + COLS);
          pv1       <= 1'b1;
          pa1       <= sweep;
          if (sweep == AW'(COPY_LAST)) begin
            state <= S_DRAIN;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end

        S_DRAIN: begin
          if (!pv1 && !pv2) begin
            state  <= S_FILL;
            sweep  <= AW'(COPY_LAST + 1);
            report <= 1'b1;
          end
        end

        S_FILL: begin
          mem_we    <= 1'b1;
          mem_waddr <= sweep;
          mem_wdata <= BLANK_CELL;
          if (sweep == AW'(CELLS - 1)) begin
            state             <= S_IDLE;
            done              <= report;
            result.cursor_row <= 5'(cur_row);
            result.cursor_col <= 7'(cur_col);
            result.cell_char  <= '0;
            result.cell_attr  <= '0;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
